// ===== hw/rtl/lbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Lagging bar meter package
// Shared types and constants for the bar meter front end, back end and top.
// ----------------------------------------------------------------------------
package lbm_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        KIND_RESET  = 2'd0,
        KIND_TARGET = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_IDLE   = 2'd3
    } t_kind;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_HOLD_FRAMES     = 3'd0,
        CFG_FLASH_FRAMES    = 3'd1,
        CFG_DRAIN_INTERVAL  = 3'd2,
        CFG_REFILL_INTERVAL = 3'd3,
        CFG_BAR_LENGTH      = 3'd4,
        CFG_LOW_THRESHOLD   = 3'd5,
        CFG_BLINK_PERIOD    = 3'd6,
        CFG_UNUSED          = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0]  hold_frames;
        logic [9:0]  flash_frames;
        logic [5:0]  drain_interval;
        logic [5:0]  refill_interval;
        logic [10:0] bar_length;
        logic [9:0]  low_threshold;
        logic [6:0]  blink_period;
    } t_cfg;

    // Back end status seen by the top level
    typedef struct packed {
        logic div_busy;
        logic out_load;
    } t_back_sts;

    // Back end sequencer states
    typedef enum logic [2:0] {
        BS_IDLE,
        BS_FRAME,
        BS_FRAME_WAIT,
        BS_APPLY,
        BS_PIX,
        BS_PIX_WAIT,
        BS_OUT
    } t_bstate;

    localparam int FIELD_W   = 16;
    localparam int PIX_W     = 11;
    localparam int FRAME_W   = 32;
    localparam int HOLD_W    = 10;
    localparam int IN_DATA_W = 32;
    localparam int OUT_W     = 72;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;

endpackage

// ===== hw/rtl/lagging_bar_meter_with_peak_trail_top.sv =====
// ----------------------------------------------------------------------------
// Lagging bar meter with peak trail
// Bar graph level meter with lagging refill, peak hold and trail drain.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one request per item. tuser carries the kind
//   (reset to level, new target, frame tick); tdata carries level and
//   level_max. Every request yields exactly one result on m_axis.
//   Configuration channel (i_cfg_*): register index and data, written while
//   the meter is idle; o_cfg_ready is always high.
// Processing:
//   A tick runs two division passes side by side over the 32-bit frame
//   count (refill and drain residues), then the pixel pass. Reset and
//   target requests skip the frame pass. The back end's restoring
//   dividers produce one bit a cycle; the back end takes the next request
//   only once the result of the last is loaded. A two-entry queue lets
//   the front take requests while the back works.
// Reset (i_rst_n low, synchronous): state returns to full scale 1, all levels
//   zero, frame count zero; registers return to their reset values.
// Stall: a result waits in the output register while m_axis_tready is low;
//   the back end holds and the queue fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module lagging_bar_meter_with_peak_trail_top import lbm_pkg::*; #(
    parameter int LEVEL_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,  // level[15:0], level_max[31:16]
    input  logic [1:0]           s_axis_tuser,  // kind[1:0]
    // Result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // shown_level[15:0], trail_level[31:16], goal_level[47:32],
    // fill_pixels[58:48], trail_pixels[69:59], low_blink_on[70],
    // trail_flashing[71]
    output logic [OUT_W-1:0]     m_axis_tdata,
    // Configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg                  r_cfg;
    t_back_sts             w_sts;
    logic                  w_q_valid, w_q_pop;
    t_kind                 w_q_kind;
    logic [LEVEL_BITS-1:0] w_q_level, w_q_scale;

    assign o_cfg_ready = 1'b1;

    // Hold configuration; take each register from the low bits of the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_frames     <= '0;
            r_cfg.flash_frames    <= '0;
            r_cfg.drain_interval  <= 6'd1;
            r_cfg.refill_interval <= 6'd1;
            r_cfg.bar_length      <= 11'd1;
            r_cfg.low_threshold   <= '0;
            r_cfg.blink_period    <= 7'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HOLD_FRAMES:     r_cfg.hold_frames     <= i_cfg_data[9:0];
                CFG_FLASH_FRAMES:    r_cfg.flash_frames    <= i_cfg_data[9:0];
                CFG_DRAIN_INTERVAL:  r_cfg.drain_interval  <= i_cfg_data[5:0];
                CFG_REFILL_INTERVAL: r_cfg.refill_interval <= i_cfg_data[5:0];
                CFG_BAR_LENGTH:      r_cfg.bar_length      <= i_cfg_data[10:0];
                CFG_LOW_THRESHOLD:   r_cfg.low_threshold   <= i_cfg_data[9:0];
                CFG_BLINK_PERIOD:    r_cfg.blink_period    <= i_cfg_data[6:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Classify and queue requests
    lbm_front #(.LEVEL_BITS(LEVEL_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_valid     (s_axis_tvalid),
        .o_s_ready     (s_axis_tready),
        .i_s_kind      (s_axis_tuser),
        .i_s_level     (s_axis_tdata[15:0]),
        .i_s_level_max (s_axis_tdata[31:16]),
        .o_q_valid     (w_q_valid),
        .i_q_pop       (w_q_pop),
        .o_q_kind      (w_q_kind),
        .o_q_level     (w_q_level),
        .o_q_scale     (w_q_scale)
    );

    // Update the meter and produce results
    lbm_back #(.LEVEL_BITS(LEVEL_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_q_kind  (w_q_kind),
        .i_q_level (w_q_level),
        .i_q_scale (w_q_scale),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_data  (m_axis_tdata),
        .o_sts     (w_sts)
    );

`ifndef SYNTHESIS
    // Never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over an untaken result");

    // A result appears only from a back end load
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_sts.out_load))
        else $error("result valid rose without a load");

    // Results are built only after every division pass has finished
    a_load_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.out_load |-> !w_sts.div_busy)
        else $error("result loaded while a divider is busy");
`endif

endmodule

// ===== hw/rtl/lbm_front.sv =====
// ----------------------------------------------------------------------------
// Bar meter front end
// Accepts items, clamps the level to full scale and queues them for the back.
// ----------------------------------------------------------------------------
module lbm_front import lbm_pkg::*; #(
    parameter int LEVEL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    output logic                  o_s_ready,
    input  logic [1:0]            i_s_kind,
    input  logic [FIELD_W-1:0]    i_s_level,
    input  logic [FIELD_W-1:0]    i_s_level_max,
    output logic                  o_q_valid,
    input  logic                  i_q_pop,
    output t_kind                 o_q_kind,
    output logic [LEVEL_BITS-1:0] o_q_level,
    output logic [LEVEL_BITS-1:0] o_q_scale
);

    t_kind                 r_kind [2];
    logic [LEVEL_BITS-1:0] r_lvl  [2];
    logic [LEVEL_BITS-1:0] r_scl  [2];
    logic                  r_wr_ptr, r_rd_ptr;
    logic [1:0]            r_count, n_count;

    logic [LEVEL_BITS-1:0] w_lvl, w_top, w_scale, w_clamped;
    logic                  w_push;

    // Mask to the level width, take a zero scale as one, clamp
    always_comb begin
        w_lvl     = LEVEL_BITS'(i_s_level);
        w_top     = LEVEL_BITS'(i_s_level_max);
        w_scale   = (w_top == '0) ? LEVEL_BITS'(1) : w_top;
        w_clamped = (w_lvl > w_scale) ? w_scale : w_lvl;
    end

    assign o_s_ready = (r_count != 2'd2);
    assign w_push    = i_s_valid && o_s_ready;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_kind  = r_kind[r_rd_ptr];
    assign o_q_level = r_lvl[r_rd_ptr];
    assign o_q_scale = r_scl[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !i_q_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_q_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_kind[r_wr_ptr] <= t_kind'(i_s_kind);
            r_lvl[r_wr_ptr]  <= w_clamped;
            r_scl[r_wr_ptr]  <= w_scale;
        end
    end

endmodule

// ===== hw/rtl/lbm_div.sv =====
// ----------------------------------------------------------------------------
// Bar meter divider
// Restoring divider, one quotient bit per cycle; divisor must be nonzero.
// ----------------------------------------------------------------------------
module lbm_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem, r_den, n_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/lbm_back.sv =====
// ----------------------------------------------------------------------------
// Bar meter back end
// Applies queued items to the meter state and builds the result word.
// ----------------------------------------------------------------------------
module lbm_back import lbm_pkg::*; #(
    parameter int LEVEL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  t_kind                 i_q_kind,
    input  logic [LEVEL_BITS-1:0] i_q_level,
    input  logic [LEVEL_BITS-1:0] i_q_scale,
    output logic                  o_m_valid,
    input  logic                  i_m_ready,
    output logic [OUT_W-1:0]      o_m_data,
    output t_back_sts             o_sts
);

    localparam int LB    = LEVEL_BITS;
    localparam int PIX_N = LB + PIX_W + 1;
    localparam int THR_W = LB + HOLD_W;

    t_bstate             r_state, n_state;
    t_kind               r_kind;
    logic [LB-1:0]       r_lvl, r_scale;
    logic [LB-1:0]       r_fs, r_goal, r_shown, r_trail;
    logic [LB-1:0]       n_fs, n_goal, n_shown, n_trail;
    logic [HOLD_W-1:0]   r_hc, n_hc;
    logic [FRAME_W-1:0]  r_fc;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    logic w_pop, w_start_frame, w_start_pix, w_apply, w_load;

    logic [5:0]          w_refill_den, w_drain_den, w_refill_rem, w_drain_rem;
    logic [6:0]          w_blink_den, w_blink_rem;
    logic [FRAME_W-1:0]  w_blink_quo;
    logic [PIX_N-1:0]    w_fill_num, w_trl_num, w_fill_quo, w_trl_quo;
    logic [LB-1:0]       w_fill_rem, w_trl_rem;
    logic                w_busy_ref, w_busy_drn, w_busy_blk, w_busy_fill, w_busy_trl;
    logic                w_frame_busy, w_pix_busy;

    logic [LB-1:0]       w_sh1;
    logic [PIX_W-1:0]    w_fill_px, w_trl_px;
    logic                w_blink, w_flash;
    logic signed [HOLD_W+1:0] w_flash_thr;

    // Intervals of zero act as one
    assign w_refill_den = (i_cfg.refill_interval == '0) ? 6'd1 : i_cfg.refill_interval;
    assign w_drain_den  = (i_cfg.drain_interval == '0) ? 6'd1 : i_cfg.drain_interval;
    assign w_blink_den  = (i_cfg.blink_period == '0) ? 7'd1 : i_cfg.blink_period;

    // Rounded pixel numerators: level * bar + scale / 2
    assign w_fill_num = PIX_N'(r_shown) * PIX_N'(i_cfg.bar_length) + PIX_N'(r_fs >> 1);
    assign w_trl_num  = PIX_N'(r_trail) * PIX_N'(i_cfg.bar_length) + PIX_N'(r_fs >> 1);

    lbm_div #(.NUM_W(FRAME_W), .DEN_W(6)) u_div_ref (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start_frame),
        .i_num(r_fc), .i_den(w_refill_den), .o_busy(w_busy_ref),
        .o_quo(), .o_rem(w_refill_rem)
    );

    lbm_div #(.NUM_W(FRAME_W), .DEN_W(6)) u_div_drn (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start_frame),
        .i_num(r_fc), .i_den(w_drain_den), .o_busy(w_busy_drn),
        .o_quo(), .o_rem(w_drain_rem)
    );

    lbm_div #(.NUM_W(FRAME_W), .DEN_W(7)) u_div_blk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start_pix),
        .i_num(r_fc), .i_den(w_blink_den), .o_busy(w_busy_blk),
        .o_quo(w_blink_quo), .o_rem(w_blink_rem)
    );

    lbm_div #(.NUM_W(PIX_N), .DEN_W(LB)) u_div_fill (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start_pix),
        .i_num(w_fill_num), .i_den(r_fs), .o_busy(w_busy_fill),
        .o_quo(w_fill_quo), .o_rem(w_fill_rem)
    );

    lbm_div #(.NUM_W(PIX_N), .DEN_W(LB)) u_div_trl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start_pix),
        .i_num(w_trl_num), .i_den(r_fs), .o_busy(w_busy_trl),
        .o_quo(w_trl_quo), .o_rem(w_trl_rem)
    );

    assign w_frame_busy = w_busy_ref || w_busy_drn;
    assign w_pix_busy   = w_busy_blk || w_busy_fill || w_busy_trl;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_kind == KIND_TICK) ? BS_FRAME : BS_APPLY;
                end
            end
            BS_FRAME:      n_state = BS_FRAME_WAIT;
            BS_FRAME_WAIT: n_state = w_frame_busy ? BS_FRAME_WAIT : BS_APPLY;
            BS_APPLY:      n_state = BS_PIX;
            BS_PIX:        n_state = BS_PIX_WAIT;
            BS_PIX_WAIT:   n_state = w_pix_busy ? BS_PIX_WAIT : BS_OUT;
            BS_OUT: begin
                if (!r_out_valid || i_m_ready) begin
                    n_state = BS_IDLE;
                end
            end
            default:       n_state = BS_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_pop         = 1'b0;
        w_start_frame = 1'b0;
        w_start_pix   = 1'b0;
        w_apply       = 1'b0;
        w_load        = 1'b0;
        case (r_state)
            BS_IDLE:  w_pop         = i_q_valid;
            BS_FRAME: w_start_frame = 1'b1;
            BS_APPLY: w_apply       = 1'b1;
            BS_PIX:   w_start_pix   = 1'b1;
            BS_OUT:   w_load        = !r_out_valid || i_m_ready;
            default: begin
                w_pop = 1'b0;
            end
        endcase
    end

    // Meter update
    always_comb begin
        n_fs    = r_fs;
        n_goal  = r_goal;
        n_shown = r_shown;
        n_trail = r_trail;
        n_hc    = r_hc;
        w_sh1   = (r_shown < r_goal && w_refill_rem == '0) ? r_shown + LB'(1) : r_shown;
        case (r_kind)
            KIND_RESET: begin
                n_fs    = r_scale;
                n_goal  = r_lvl;
                n_shown = r_lvl;
                n_trail = r_lvl;
                n_hc    = '0;
            end
            KIND_TARGET: begin
                n_fs   = r_scale;
                n_goal = r_lvl;
                if (r_lvl < r_goal) begin
                    n_trail = (r_shown > r_trail) ? r_shown : r_trail;
                    n_shown = r_lvl;
                    n_hc    = i_cfg.hold_frames;
                end
            end
            KIND_TICK: begin
                n_shown = w_sh1;
                if (r_trail <= w_sh1) begin
                    n_trail = w_sh1;
                end else if (r_hc != '0) begin
                    n_hc = r_hc - HOLD_W'(1);
                end else if (w_drain_rem == '0) begin
                    n_trail = r_trail - LB'(1);
                end
            end
            default: begin
                n_fs = r_fs;
            end
        endcase
    end

    // Result fields; pixel counts saturate at the bar length
    always_comb begin
        w_fill_px = (w_fill_quo > PIX_N'(i_cfg.bar_length)) ? i_cfg.bar_length
                                                            : w_fill_quo[PIX_W-1:0];
        w_trl_px  = (w_trl_quo > PIX_N'(i_cfg.bar_length)) ? i_cfg.bar_length
                                                           : w_trl_quo[PIX_W-1:0];
        w_blink   = (r_shown != '0) &&
                    (THR_W'(r_shown) <= THR_W'(i_cfg.low_threshold)) &&
                    w_blink_quo[0];
        w_flash_thr = $signed({2'b00, i_cfg.hold_frames}) -
                      $signed({2'b00, i_cfg.flash_frames});
        w_flash   = $signed({2'b00, r_hc}) > w_flash_thr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_fs        <= LB'(1);
            r_goal      <= '0;
            r_shown     <= '0;
            r_trail     <= '0;
            r_hc        <= '0;
            r_fc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_pop && i_q_kind == KIND_TICK) begin
                r_fc <= r_fc + FRAME_W'(1);
            end
            if (w_apply) begin
                r_fs    <= n_fs;
                r_goal  <= n_goal;
                r_shown <= n_shown;
                r_trail <= n_trail;
                r_hc    <= n_hc;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_kind  <= i_q_kind;
            r_lvl   <= i_q_level;
            r_scale <= i_q_scale;
        end
        if (w_load) begin
            r_out_data <= {w_flash, w_blink, w_trl_px, w_fill_px,
                           FIELD_W'(r_goal), FIELD_W'(r_trail), FIELD_W'(r_shown)};
        end
    end

    assign o_q_pop        = w_pop;
    assign o_m_valid      = r_out_valid;
    assign o_m_data       = r_out_data;
    assign o_sts.div_busy = w_frame_busy || w_pix_busy;
    assign o_sts.out_load = w_load;

endmodule
